@@ rtl/fwdp_pkg.sv @@
// ----------------------------------------------------------------------------
// Fixed-width decimal field parser package
// Shared types, character codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package fwdp_pkg;

	localparam int VALUE_BITS_DEF = 64;
	localparam int VALUE_OUT_BITS = 64;
	localparam int CFG_DATA_BITS  = 5;
	localparam int CFG_IDX_BITS   = 1;

	localparam logic [CFG_IDX_BITS-1:0] REG_FIELD_WIDTH = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FRAC_DIGITS = 1'd1;

	localparam logic [4:0] FIELD_WIDTH_RST = 5'd14;
	localparam logic [4:0] FRAC_DIGITS_RST = 5'd3;

	localparam logic [7:0] CHAR_DOT     = 8'h2E;
	localparam logic [7:0] CHAR_MINUS   = 8'h2D;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_NINE    = 8'h39;

	typedef enum logic [2:0] {
		PH_LEAD,
		PH_INT,
		PH_FRAC,
		PH_TRAIL,
		PH_PAD
	} phase_t;

	// Per-field control state, everything except the accumulator.
	typedef struct packed {
		logic [4:0] position;
		phase_t     phase;
		logic       negative;
		logic       error_seen;
	} ctrl_t;

	localparam ctrl_t CTRL_RESTART = '{
		position:   5'd0,
		phase:      PH_LEAD,
		negative:   1'b0,
		error_seen: 1'b0
	};

endpackage

@@ rtl/fixed_width_decimal_field_parser_core.sv @@
// ----------------------------------------------------------------------------
// Fixed-width decimal field parser core
// Parses fixed-width decimal text fields, one character per item, into
// scaled two's complement integers with a format error flag.
// ----------------------------------------------------------------------------
// The block takes one character per clock cycle unless the input stalls, and
// gives one result after the last column of each field. Each accepted
// character is held in the input register while the character step (a
// multiply by ten built from shifts and an add, followed by the sign negation)
// works on it; when the last column's character moves on, the result register
// is written and drives the output. Back-pressure on the
// result side stalls the input only when a finished result is still waiting
// and the character in the input register closes another field. A
// configuration write restarts the current field; it is meant to be issued
// while idle.
module fixed_width_decimal_field_parser_core #(
	parameter int VALUE_BITS = fwdp_pkg::VALUE_BITS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       cfg_write,
	input  logic [fwdp_pkg::CFG_IDX_BITS-1:0]          cfg_index,
	input  logic [fwdp_pkg::CFG_DATA_BITS-1:0]         cfg_data,
	input  logic                                       in_valid,
	output logic                                       in_ready,
	input  logic [7:0]                                 char_in,
	output logic                                       out_valid,
	input  logic                                       out_ready,
	output logic signed [fwdp_pkg::VALUE_OUT_BITS-1:0] value,
	output logic                                       bad_format
);
	import fwdp_pkg::*;

	logic [4:0]            field_width_q;
	logic [4:0]            frac_digits_q;
	logic                  valid_s1;
	logic [7:0]            char_s1;
	ctrl_t                 ctrl_q;
	logic [VALUE_BITS-1:0] acc_q;
	logic                  out_valid_q;
	logic signed [VALUE_OUT_BITS-1:0] value_q;
	logic                  bad_q;

	ctrl_t                 ctrl_next;
	logic [VALUE_BITS-1:0] acc_next;
	logic                  last;
	logic signed [VALUE_OUT_BITS-1:0] step_value;
	logic                  step_bad;
	logic                  out_free;
	logic                  advance;

	fwdp_step #(
		.VALUE_BITS(VALUE_BITS)
	) u_step (
		.field_width(field_width_q),
		.frac_digits(frac_digits_q),
		.ctrl       (ctrl_q),
		.acc        (acc_q),
		.char_in    (char_s1),
		.ctrl_next  (ctrl_next),
		.acc_next   (acc_next),
		.last       (last),
		.value      (step_value),
		.bad_format (step_bad)
	);

	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && (!last || out_free);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_width_q <= FIELD_WIDTH_RST;
			frac_digits_q <= FRAC_DIGITS_RST;
			valid_s1      <= 1'b0;
			ctrl_q        <= CTRL_RESTART;
			acc_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end

			if (cfg_write) begin
				unique case (cfg_index)
					REG_FIELD_WIDTH: field_width_q <= cfg_data;
					REG_FRAC_DIGITS: frac_digits_q <= cfg_data;
					default:         field_width_q <= field_width_q;
				endcase
				ctrl_q <= CTRL_RESTART;
				acc_q  <= '0;
			end else if (advance) begin
				if (last) begin
					ctrl_q <= CTRL_RESTART;
					acc_q  <= '0;
				end else begin
					ctrl_q <= ctrl_next;
					acc_q  <= acc_next;
				end
			end

			if (advance && last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_in;
		end
		if (advance && last) begin
			value_q <= step_value;
			bad_q   <= step_bad;
		end
	end

	assign out_valid  = out_valid_q;
	assign value      = value_q;
	assign bad_format = bad_q;

	// A malformed field always reports a zero value.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && bad_q |-> value_q == '0)
		else $error("bad_format result carries a non-zero value");

	// The column counter never reaches the effective field width.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, ctrl_q.position} < {1'b0, field_width_q}) ||
		(ctrl_q.position == 5'd0))
		else $error("column counter beyond field width");

	// The input stalls only behind a waiting result and a closing character.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready && last)
		else $error("input stalled without cause");

	// A closing character that moves on always yields a result next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last |=> out_valid_q)
		else $error("field closed without a result");

endmodule

@@ rtl/fwdp_step.sv @@
// ----------------------------------------------------------------------------
// Fixed-width decimal field parser: character step
// Combinational next-state logic for one character, plus the finished value
// when the character closes the field.
// ----------------------------------------------------------------------------
module fwdp_step #(
	parameter int VALUE_BITS = fwdp_pkg::VALUE_BITS_DEF
) (
	input  logic [4:0]                          field_width,
	input  logic [4:0]                          frac_digits,
	input  fwdp_pkg::ctrl_t                     ctrl,
	input  logic [VALUE_BITS-1:0]               acc,
	input  logic [7:0]                          char_in,
	output fwdp_pkg::ctrl_t                     ctrl_next,
	output logic [VALUE_BITS-1:0]               acc_next,
	output logic                                last,
	output logic signed [fwdp_pkg::VALUE_OUT_BITS-1:0] value,
	output logic                                bad_format
);
	import fwdp_pkg::*;

	logic [4:0]            width_eff;
	logic [4:0]            dot_pos;
	logic                  is_digit;
	logic [3:0]            digit;
	logic                  push;
	logic [3:0]            push_val;
	logic [VALUE_BITS-1:0] signed_v;

	assign width_eff = (field_width == 5'd0) ? 5'd1 : field_width;
	assign dot_pos   = (frac_digits < width_eff) ? (width_eff - frac_digits - 5'd1) : 5'd0;
	assign is_digit  = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
	assign digit     = 4'(char_in - CHAR_ZERO);
	assign last      = ({1'b0, ctrl.position} + 6'd1) >= {1'b0, width_eff};

	always_comb begin
		ctrl_next          = ctrl;
		ctrl_next.position = ctrl.position + 5'd1;
		push               = 1'b0;
		push_val           = 4'd0;
		unique case (ctrl.phase)
			PH_LEAD, PH_INT: begin
				if (ctrl.position >= dot_pos) begin
					if (char_in != CHAR_DOT) begin
						ctrl_next.error_seen = 1'b1;
					end
					ctrl_next.phase = PH_FRAC;
				end else if (ctrl.phase == PH_LEAD && char_in == CHAR_SPACE) begin
					ctrl_next.phase = PH_LEAD;
				end else if (ctrl.phase == PH_LEAD && char_in == CHAR_MINUS) begin
					ctrl_next.negative = 1'b1;
					ctrl_next.phase    = PH_INT;
				end else begin
					if (is_digit) begin
						push     = 1'b1;
						push_val = digit;
					end else begin
						ctrl_next.error_seen = 1'b1;
					end
					ctrl_next.phase = PH_INT;
				end
			end
			PH_FRAC, PH_TRAIL: begin
				push = 1'b1;
				if (ctrl.phase == PH_FRAC && is_digit) begin
					push_val = digit;
				end else if (char_in == CHAR_NEWLINE) begin
					ctrl_next.phase = PH_PAD;
				end else begin
					if (char_in != CHAR_SPACE) begin
						ctrl_next.error_seen = 1'b1;
					end
					ctrl_next.phase = PH_TRAIL;
				end
			end
			default: begin
				// After a newline every column is a zero digit.
				push            = 1'b1;
				ctrl_next.phase = PH_PAD;
			end
		endcase
	end

	// Times ten as two shifts and an add; the sum wraps at the accumulator width.
	assign acc_next = push ? ((acc << 3) + (acc << 1) + VALUE_BITS'(push_val)) : acc;

	assign signed_v   = ctrl_next.negative ? (VALUE_BITS'(0) - acc_next) : acc_next;
	assign bad_format = ctrl_next.error_seen;
	assign value      = ctrl_next.error_seen ? '0 : VALUE_OUT_BITS'($signed(signed_v));

endmodule
